@@ rtl/point_transform_bounds_centroid_macros.svh @@
// Assertion macros shared by the point transform block.
// Depends on nothing; included by the top level only.
`ifndef POINT_TRANSFORM_BOUNDS_CENTROID_MACROS_SVH
`define POINT_TRANSFORM_BOUNDS_CENTROID_MACROS_SVH

// Assert that a condition implies a consequent in the same cycle.
`define PTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequent in the next cycle.
`define PTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ptbc_pkg.sv @@
// Package for the point transform block: types, constants and helpers.
// Used by every module of the block.
package ptbc_pkg;

    localparam int unsigned SUM_W = 52;
    localparam int unsigned CNT_W = 21;
    localparam int unsigned EXT_W = 13;
    localparam int unsigned OBJ_W = 9;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_BOX      = 2'd1,
        KIND_CENTROID = 2'd2
    } kind_t;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_ROT0   = 3'd0,
        REG_ROT1   = 3'd1,
        REG_ROT2   = 3'd2,
        REG_SHIFTX = 3'd3,
        REG_SHIFTY = 3'd4,
        REG_SHIFTZ = 3'd5
    } reg_idx_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_POINT,
        ST_BOX,
        ST_DIV,
        ST_CENT
    } back_state_t;

    // One queued point as classified by the front end.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [EXT_W-1:0]   width_cand;
        logic [EXT_W-1:0]   height_cand;
        logic [OBJ_W-1:0]   obj_cand;
        logic               last_point;
    } item_t;

    // Result word handed to the output register.
    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic signed [31:0] v3;
        logic signed [31:0] v4;
        logic signed [31:0] v5;
        logic               last_result;
    } result_t;

    // Saturate an exact signed sum to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [51:0] lim_hi;
        logic signed [51:0] lim_lo;
        begin
            lim_hi = 52'sd2147483647;
            lim_lo = -52'sd2147483648;
            if (v > lim_hi)
                sat32 = 32'sh7fffffff;
            else if (v < lim_lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        begin
            if (v > 36'sd32767)
                sat16 = 16'sh7fff;
            else if (v < -36'sd32768)
                sat16 = 16'sh8000;
            else
                sat16 = v[15:0];
        end
    endfunction

endpackage

@@ rtl/ptbc_front.sv @@
// Front end: classifies a point and precomputes its extent and object candidates.
// Depends on ptbc_pkg.
module ptbc_front #(
    parameter int unsigned DEPTH_SIZE = 4096
) (
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [15:0]   norm_x,
    input  logic signed [15:0]   norm_y,
    input  logic signed [15:0]   norm_z,
    input  logic [11:0]          depth_col,
    input  logic [11:0]          depth_row,
    input  logic signed [8:0]    obj_label,
    input  logic                 last_point,
    output ptbc_pkg::item_t      item
);
    import ptbc_pkg::*;

    localparam logic [16:0] DSZ = 17'(DEPTH_SIZE);

    logic [16:0] col_p1;
    logic [16:0] row_p1;

    // Extents saturate at the image size; negative ids count as zero.
    always_comb
    begin
        col_p1 = 17'(depth_col) + 17'd1;
        row_p1 = 17'(depth_row) + 17'd1;
        item.pos_x = pos_x;
        item.pos_y = pos_y;
        item.pos_z = pos_z;
        item.norm_x = norm_x;
        item.norm_y = norm_y;
        item.norm_z = norm_z;
        item.width_cand  = (col_p1 > DSZ) ? DSZ[EXT_W-1:0] : col_p1[EXT_W-1:0];
        item.height_cand = (row_p1 > DSZ) ? DSZ[EXT_W-1:0] : row_p1[EXT_W-1:0];
        item.obj_cand = obj_label[8] ? '0 : 9'(obj_label + 9'sd1);
        item.last_point = last_point;
    end

endmodule

@@ rtl/ptbc_queue.sv @@
// Two-entry word queue between the front and back ends.
// Depends on ptbc_pkg.
module ptbc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ptbc_pkg::item_t   push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output ptbc_pkg::item_t   head
);
    import ptbc_pkg::*;

    item_t       mem_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head = mem_reg[rp_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

endmodule

@@ rtl/ptbc_back.sv @@
// Back end: transform, statistics, bounding box and centroid division.
// Depends on ptbc_pkg.
module ptbc_back #(
    parameter int unsigned MAX_POINTS = 1048576
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [47:0]        rot_row0,
    input  logic [47:0]        rot_row1,
    input  logic [47:0]        rot_row2,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    input  logic signed [31:0] shift_z,
    input  logic               q_valid,
    input  ptbc_pkg::item_t    q_item,
    output logic               q_pop,
    output logic               res_valid,
    output ptbc_pkg::result_t  res,
    input  logic               res_ready,
    output logic               busy
);
    import ptbc_pkg::*;

    localparam logic [CNT_W:0] MAXP = (MAX_POINTS > (1 << CNT_W)) ?
        (CNT_W+1)'(1 << CNT_W) : (CNT_W+1)'(MAX_POINTS);

    back_state_t state_reg, state_next;

    item_t              it_reg;
    logic signed [47:0] pp_reg [9];
    logic signed [31:0] np_reg [9];
    logic signed [31:0] tp_reg [3];
    logic signed [15:0] tn_reg [3];

    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [31:0]      min_reg [3];
    logic signed [31:0]      max_reg [3];
    logic [EXT_W-1:0]        wid_reg;
    logic [EXT_W-1:0]        hgt_reg;
    logic [OBJ_W-1:0]        obj_reg;
    logic [CNT_W:0]          cnt_reg;

    // Divider: restoring, one quotient bit per cycle on the magnitude.
    logic [SUM_W-1:0]  dq_reg [3];
    logic [CNT_W:0]    drem_reg [3];
    logic              dneg_reg [3];
    logic [5:0]        dstep_reg;
    logic signed [31:0] cent_reg [3];

    logic signed [15:0] ent [9];
    logic signed [31:0] pin [3];
    logic signed [15:0] nin [3];
    logic signed [51:0] apos [3];
    logic signed [35:0] anor [3];

    logic load_item;

    // Unpack rotation entries.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ent[c]     = rot_row0[16*c +: 16];
            ent[3 + c] = rot_row1[16*c +: 16];
            ent[6 + c] = rot_row2[16*c +: 16];
        end
        pin[0] = it_reg.pos_x;
        pin[1] = it_reg.pos_y;
        pin[2] = it_reg.pos_z;
        nin[0] = it_reg.norm_x;
        nin[1] = it_reg.norm_y;
        nin[2] = it_reg.norm_z;
    end

    // Row sums; arithmetic shift is floor division by 2^14.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            apos[r] = (52'(pp_reg[3*r]) + 52'(pp_reg[3*r+1]) + 52'(pp_reg[3*r+2])) >>> 14;
            anor[r] = (36'(np_reg[3*r]) + 36'(np_reg[3*r+1]) + 36'(np_reg[3*r+2])) >>> 14;
        end
        apos[0] = apos[0] + 52'(shift_x);
        apos[1] = apos[1] + 52'(shift_y);
        apos[2] = apos[2] + 52'(shift_z);
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        load_item = 1'b0;
        res_valid = 1'b0;
        res = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    load_item = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_SUM;
            ST_SUM:
            begin
                state_next = ST_POINT;
            end
            ST_POINT:
            begin
                res_valid = 1'b1;
                res.kind = KIND_POINT;
                res.v0 = tp_reg[0];
                res.v1 = tp_reg[1];
                res.v2 = tp_reg[2];
                res.v3 = 32'(tn_reg[0]);
                res.v4 = 32'(tn_reg[1]);
                res.v5 = 32'(tn_reg[2]);
                res.last_result = ~it_reg.last_point;
                if (res_ready)
                    state_next = it_reg.last_point ? ST_BOX : ST_IDLE;
            end
            ST_BOX:
            begin
                res_valid = 1'b1;
                res.kind = KIND_BOX;
                res.v0 = min_reg[0];
                res.v1 = min_reg[1];
                res.v2 = min_reg[2];
                res.v3 = max_reg[0];
                res.v4 = max_reg[1];
                res.v5 = max_reg[2];
                if (res_ready)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dstep_reg == 6'(SUM_W))
                    state_next = ST_CENT;
            end
            ST_CENT:
            begin
                res_valid = 1'b1;
                res.kind = KIND_CENTROID;
                res.v0 = cent_reg[0];
                res.v1 = cent_reg[1];
                res.v2 = cent_reg[2];
                res.v3 = 32'(wid_reg);
                res.v4 = 32'(hgt_reg);
                res.v5 = 32'(obj_reg);
                res.last_result = 1'b1;
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath: item capture, products, transform results.
    always_ff @(posedge clk)
    begin
        if (load_item)
            it_reg <= q_item;
        if (state_reg == ST_MUL)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    pp_reg[3*r+c] <= 48'(ent[3*r+c]) * 48'(pin[c]);
                    np_reg[3*r+c] <= 32'(ent[3*r+c]) * 32'(nin[c]);
                end
        end
        if (state_reg == ST_SUM)
        begin
            for (int r = 0; r < 3; r++)
            begin
                tp_reg[r] <= sat32(apos[r]);
                tn_reg[r] <= sat16(anor[r]);
            end
        end
    end

    // Running statistics, cleared after the centroid word leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= '0;
                min_reg[r] <= 32'sh7fffffff;
                max_reg[r] <= 32'sh80000000;
            end
            wid_reg <= '0;
            hgt_reg <= '0;
            obj_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == ST_CENT && res_ready)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= '0;
                min_reg[r] <= 32'sh7fffffff;
                max_reg[r] <= 32'sh80000000;
            end
            wid_reg <= '0;
            hgt_reg <= '0;
            obj_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == ST_POINT && cnt_reg < MAXP && res_ready)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= sum_reg[r] + SUM_W'(tp_reg[r]);
                if (tp_reg[r] < min_reg[r])
                    min_reg[r] <= tp_reg[r];
                if (tp_reg[r] > max_reg[r])
                    max_reg[r] <= tp_reg[r];
            end
            if (it_reg.width_cand > wid_reg)
                wid_reg <= it_reg.width_cand;
            if (it_reg.height_cand > hgt_reg)
                hgt_reg <= it_reg.height_cand;
            if (it_reg.obj_cand > obj_reg)
                obj_reg <= it_reg.obj_cand;
            cnt_reg <= cnt_reg + (CNT_W+1)'(1);
        end
    end

    // Bit-serial division of the three sums by the point count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dstep_reg <= '0;
        else if (state_reg == ST_BOX)
            dstep_reg <= '0;
        else if (state_reg == ST_DIV && dstep_reg != 6'(SUM_W))
            dstep_reg <= dstep_reg + 6'd1;
    end

    always_ff @(posedge clk)
    begin
        logic [CNT_W+1:0] trial;
        if (state_reg == ST_BOX)
        begin
            for (int r = 0; r < 3; r++)
            begin
                dneg_reg[r] <= sum_reg[r][SUM_W-1];
                dq_reg[r] <= sum_reg[r][SUM_W-1] ? SUM_W'(-sum_reg[r]) : sum_reg[r];
                drem_reg[r] <= '0;
            end
        end
        else if (state_reg == ST_DIV && dstep_reg != 6'(SUM_W))
        begin
            for (int r = 0; r < 3; r++)
            begin
                trial = {drem_reg[r], dq_reg[r][SUM_W-1]};
                if (trial >= (CNT_W+2)'(cnt_reg))
                begin
                    drem_reg[r] <= (CNT_W+1)'(trial - (CNT_W+2)'(cnt_reg));
                    dq_reg[r] <= {dq_reg[r][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[r] <= trial[CNT_W:0];
                    dq_reg[r] <= {dq_reg[r][SUM_W-2:0], 1'b0};
                end
            end
        end
        else if (state_reg == ST_DIV)
        begin
            for (int r = 0; r < 3; r++)
                cent_reg[r] <= dneg_reg[r] ? 32'(-dq_reg[r]) : 32'(dq_reg[r]);
        end
    end

endmodule

@@ rtl/point_transform_bounds_centroid.sv @@
// Top level of the point transform block with bounds and centroid.
// Depends on ptbc_pkg, ptbc_front, ptbc_queue, ptbc_back and the macros header.
//
// Channel  Direction  Handshake          Word
// in       input      in_valid/in_ready  one point
// out      output     out_valid/out_ready one result
// apb      input      psel/penable       one register write or read
//
// A point passes through the back end's capture, multiply and sum states, then sends its result words.
// A last point also passes through the bit-serial centroid divider after its box word.
// Reset is asynchronous and restores the identity transform and clear statistics.
// A stalled output holds the back end; the two-entry queue accepts until it is full.
`include "point_transform_bounds_centroid_macros.svh"
module point_transform_bounds_centroid #(
    parameter int unsigned MAX_POINTS = 1048576,
    parameter int unsigned DEPTH_SIZE = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic [11:0]        depth_col,
    input  logic [11:0]        depth_row,
    input  logic signed [8:0]  obj_label,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic signed [31:0] value0,
    output logic signed [31:0] value1,
    output logic signed [31:0] value2,
    output logic signed [31:0] value3,
    output logic signed [31:0] value4,
    output logic signed [31:0] value5,
    output logic               last_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import ptbc_pkg::*;

    logic [47:0]        rot_reg [3];
    logic signed [31:0] shift_reg [3];
    reg_idx_t           widx;
    logic               wr_en;

    item_t   f_item;
    item_t   q_head;
    logic    q_full;
    logic    q_ne;
    logic    q_pop;
    logic    b_busy;
    logic    b_valid;
    result_t b_res;
    logic    b_ready;

    result_t o_reg;
    logic    ov_reg;
    logic    in_acc;

    // Configuration registers.
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign widx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= 48'd16384;
            rot_reg[1] <= 48'd1073741824;
            rot_reg[2] <= 48'd70368744177664;
            for (int i = 0; i < 3; i++)
                shift_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_ROT0:   rot_reg[0] <= pwdata[47:0];
                REG_ROT1:   rot_reg[1] <= pwdata[47:0];
                REG_ROT2:   rot_reg[2] <= pwdata[47:0];
                REG_SHIFTX: shift_reg[0] <= pwdata[31:0];
                REG_SHIFTY: shift_reg[1] <= pwdata[31:0];
                REG_SHIFTZ: shift_reg[2] <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (widx)
            REG_ROT0:   prdata = 64'(rot_reg[0]);
            REG_ROT1:   prdata = 64'(rot_reg[1]);
            REG_ROT2:   prdata = 64'(rot_reg[2]);
            REG_SHIFTX: prdata = 64'(unsigned'(shift_reg[0]));
            REG_SHIFTY: prdata = 64'(unsigned'(shift_reg[1]));
            REG_SHIFTZ: prdata = 64'(unsigned'(shift_reg[2]));
            default:    prdata = '0;
        endcase
    end

    // Front end and queue.
    assign in_ready = !q_full;
    assign in_acc = in_valid && in_ready;

    ptbc_front #(.DEPTH_SIZE(DEPTH_SIZE)) u_front (
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .depth_col(depth_col), .depth_row(depth_row),
        .obj_label(obj_label), .last_point(last_point),
        .item(f_item)
    );

    ptbc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in_acc), .push_data(f_item), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    ptbc_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .rot_row0(rot_reg[0]), .rot_row1(rot_reg[1]), .rot_row2(rot_reg[2]),
        .shift_x(shift_reg[0]), .shift_y(shift_reg[1]), .shift_z(shift_reg[2]),
        .q_valid(q_ne), .q_item(q_head), .q_pop(q_pop),
        .res_valid(b_valid), .res(b_res), .res_ready(b_ready),
        .busy(b_busy)
    );

    // Output register.
    assign b_ready = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (b_ready)
            ov_reg <= b_valid;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && b_valid)
            o_reg <= b_res;
    end

    assign out_valid = ov_reg;
    assign kind = o_reg.kind;
    assign value0 = o_reg.v0;
    assign value1 = o_reg.v1;
    assign value2 = o_reg.v2;
    assign value3 = o_reg.v3;
    assign value4 = o_reg.v4;
    assign value5 = o_reg.v5;
    assign last_result = o_reg.last_result;

    // Checks.
    `PTB_ASSERT_IMP(a_pop_needs_item, clk, rst_n, q_pop, q_ne, "pop from empty queue")
    `PTB_ASSERT_IMP(a_pop_idle_only, clk, rst_n, q_pop, !b_busy, "pop while back end busy")
    `PTB_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind), "output word dropped")

endmodule
